// File: hw/rtl/bha_pkg.sv
// Shared types, codes and helper functions for the binned histogram accumulator.
`timescale 1ns / 1ps
package bha_pkg;

    typedef enum logic [2:0] {
        OP_COUNT = 3'd0,
        OP_CLEAR = 3'd1,
        OP_READ  = 3'd2,
        OP_RISE  = 3'd3,
        OP_FALL  = 3'd4
    } bha_op_t;

    typedef enum logic [1:0] {
        REG_X_LOW  = 2'd0,
        REG_BPU    = 2'd1,
        REG_BINS   = 2'd2
    } bha_reg_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CNT_MUL,
        S_CNT_RD,
        S_CNT_WR,
        S_RD_RD,
        S_RD_WAIT,
        S_Q_RD,
        S_Q_CHK,
        S_Q_DIV1,
        S_Q_DIV2,
        S_Q_MUL,
        S_Q_SHF,
        S_DONE
    } bha_state_t;

    typedef struct packed {
        logic signed [63:0] sum_x;
        logic signed [63:0] sum_y;
        logic [31:0]        cnt;
    } bha_entry_t;

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [31:0] b);
        logic [64:0] s;
        s = {a[63], a} + {{33{b[31]}}, b};
        if (s[64] != s[63])
            sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
            sat_add64 = s[63:0];
    endfunction

    function automatic logic [31:0] sat_inc32(input logic [31:0] c);
        sat_inc32 = (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

endpackage

// File: hw/rtl/binned_histogram_accumulator.sv
// Binned histogram accumulator: register port, sequencer and shared datapath.
//
// Usage: one input word per operation (count, clear, read bin, two crossing
// queries) on in_valid/in_ready; one result word per operation on
// out_valid/out_ready. Configuration through the APB port while idle.
// A rejected count sample skips the bin read and write; in_ready rises with
// out_valid. Queries walk the active bins in order and skip empty ones; each
// non-empty bin's mean goes through the 64-step divider, and the crossing
// bin goes through it once more (then a multiply and shift for falling y).
// One word is worked on at a time; the next word is taken as soon as the
// sequencer is idle, even while the last result waits on out_ready.
// A stalled result holds until taken; a finished word waits behind it.
// After reset the block sweeps all MAX_BINS entries of the bin memory to zero
// with in_ready low; configuration writes are taken throughout.
`timescale 1ns / 1ps
module binned_histogram_accumulator #(
    parameter int MAX_BINS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         opcode,
    input  logic signed [31:0] sample_x,
    input  logic signed [31:0] sample_y,
    input  logic [9:0]         bin_select,
    input  logic signed [31:0] target,
    input  logic signed [31:0] x_scale,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               in_range,
    output logic signed [63:0] bin_sum_x,
    output logic signed [63:0] bin_sum_y,
    output logic [31:0]        bin_count,
    output logic [31:0]        total_counted,
    output logic [31:0]        rejected_count,
    output logic               found,
    output logic signed [31:0] query_value
);
    import bha_pkg::*;

    localparam int AW = $clog2(MAX_BINS);
    localparam int NW = (AW + 1 > 11) ? AW + 1 : 11;

    // configuration
    logic signed [31:0] x_low_reg;
    logic [31:0]        bpu_reg;
    logic [10:0]        bins_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_low_reg <= '0;
            bpu_reg   <= 32'd65536;
            bins_reg  <= 11'd1024;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_X_LOW: x_low_reg <= pwdata;
                REG_BPU:   bpu_reg   <= pwdata;
                REG_BINS:  bins_reg  <= pwdata[10:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_X_LOW: prdata = x_low_reg;
            REG_BPU:   prdata = bpu_reg;
            REG_BINS:  prdata = {21'd0, bins_reg};
            default:   prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    logic [NW-1:0] nb;
    assign nb = (NW'(bins_reg) < NW'(MAX_BINS)) ? NW'(bins_reg) : NW'(MAX_BINS);

    // state
    bha_state_t state_reg, state_next;
    logic [AW-1:0]      clr_idx_reg;
    logic               clr_op_reg;
    logic [31:0]        total_reg;
    logic [31:0]        outside_reg;
    logic               out_valid_reg;

    logic [2:0]         op_reg;
    logic signed [31:0] sx_reg, sy_reg, tgt_reg, scale_reg;
    logic [9:0]         sel_reg;
    logic               ge_reg;
    logic signed [65:0] mul_reg;
    logic [AW-1:0]      bin_reg;
    logic [AW:0]        idx_reg;
    logic signed [31:0] prev_reg, m2_reg;
    bha_entry_t         ent_reg;

    logic               w_inr_reg, w_fnd_reg;
    logic signed [63:0] w_bx_reg, w_by_reg;
    logic [31:0]        w_bc_reg;
    logic signed [31:0] w_qv_reg;

    logic               o_inr_reg, o_fnd_reg;
    logic signed [63:0] o_bx_reg, o_by_reg;
    logic [31:0]        o_bc_reg, o_tot_reg, o_out_reg;
    logic signed [31:0] o_qv_reg;

    // memory and divider hookup
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    bha_entry_t         mem_wdata, mem_rdata;
    logic               div_start, div_done;
    logic signed [63:0] div_dvd;
    logic [31:0]        div_dvs;
    logic signed [31:0] div_q;

    bha_mem #(.DEPTH(MAX_BINS)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bha_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    // shared multiplier
    logic signed [32:0] diff, mul_a, mul_b;
    logic signed [65:0] mul_p;
    assign diff = {sx_reg[31], sx_reg} - {x_low_reg[31], x_low_reg};

    always_comb
    begin
        if (state_reg == S_CNT_MUL)
        begin
            mul_a = {1'b0, diff[31:0]};
            mul_b = {1'b0, bpu_reg};
        end
        else
        begin
            mul_a = {scale_reg[31], scale_reg};
            mul_b = {m2_reg[31], m2_reg};
        end
    end
    assign mul_p = mul_a * mul_b;

    logic               cnt_ok;
    logic [AW-1:0]      cnt_bin;
    logic [AW+9:0]      sel_wide;
    logic               sel_ok;
    logic               hit;
    logic [49:0]        shf;
    logic signed [31:0] shf_sat;
    bha_entry_t         upd;

    assign cnt_ok   = ge_reg && (mul_reg[63:16] < {{(48 - NW){1'b0}}, nb});
    assign cnt_bin  = mul_reg[16 + AW - 1:16];
    assign sel_wide = {{AW{1'b0}}, sel_reg};
    assign sel_ok   = {22'd0, sel_reg} < 32'(MAX_BINS);
    assign hit      = (op_reg == OP_RISE) ?
                      (div_q > tgt_reg && prev_reg < tgt_reg) :
                      (div_q < tgt_reg && prev_reg > tgt_reg);
    assign shf      = mul_reg[65:16];
    assign shf_sat  = (shf[49:31] == {19{shf[49]}}) ? shf[31:0] :
                      (shf[49] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

    always_comb
    begin
        upd.sum_x = sat_add64(mem_rdata.sum_x, sx_reg);
        upd.sum_y = sat_add64(mem_rdata.sum_y, sy_reg);
        upd.cnt   = sat_inc32(mem_rdata.cnt);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = clr_idx_reg;
        mem_wdata  = '0;
        mem_raddr  = idx_reg[AW-1:0];
        div_start  = 1'b0;
        div_dvd    = (op_reg == OP_RISE) ? mem_rdata.sum_x : mem_rdata.sum_y;
        div_dvs    = mem_rdata.cnt;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (clr_idx_reg == AW'(MAX_BINS - 1))
                    state_next = clr_op_reg ? S_DONE : S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (opcode)
                        OP_COUNT: state_next = S_CNT_MUL;
                        OP_CLEAR: state_next = S_CLEAR;
                        OP_READ:  state_next = S_RD_RD;
                        OP_RISE:  state_next = S_Q_RD;
                        OP_FALL:  state_next = S_Q_RD;
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_CNT_MUL: state_next = S_CNT_RD;
            S_CNT_RD:
            begin
                if (cnt_ok)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = cnt_bin;
                    state_next = S_CNT_WR;
                end
                else
                    state_next = S_DONE;
            end
            S_CNT_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = bin_reg;
                mem_wdata  = upd;
                state_next = S_DONE;
            end
            S_RD_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = sel_wide[AW-1:0];
                state_next = S_RD_WAIT;
            end
            S_RD_WAIT: state_next = S_DONE;
            S_Q_RD:
            begin
                if (NW'(idx_reg) >= nb)
                    state_next = S_DONE;
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_Q_CHK;
                end
            end
            S_Q_CHK:
            begin
                if (mem_rdata.cnt == 32'd0)
                    state_next = S_Q_RD;
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_Q_DIV1;
                end
            end
            S_Q_DIV1:
            begin
                div_dvd = (op_reg == OP_RISE) ? ent_reg.sum_y : ent_reg.sum_x;
                div_dvs = ent_reg.cnt;
                if (div_done)
                begin
                    if (hit)
                    begin
                        div_start  = 1'b1;
                        state_next = S_Q_DIV2;
                    end
                    else
                        state_next = S_Q_RD;
                end
            end
            S_Q_DIV2:
            begin
                if (div_done)
                    state_next = (op_reg == OP_RISE) ? S_DONE : S_Q_MUL;
            end
            S_Q_MUL: state_next = S_Q_SHF;
            S_Q_SHF: state_next = S_DONE;
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            clr_op_reg    <= 1'b0;
            total_reg     <= '0;
            outside_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR: clr_idx_reg <= clr_idx_reg + AW'(1);
                S_IDLE:
                begin
                    if (in_valid && opcode == OP_CLEAR)
                    begin
                        clr_idx_reg <= '0;
                        clr_op_reg  <= 1'b1;
                        total_reg   <= '0;
                        outside_reg <= '0;
                    end
                end
                S_CNT_RD:
                begin
                    if (!cnt_ok)
                        outside_reg <= sat_inc32(outside_reg);
                end
                S_CNT_WR: total_reg <= sat_inc32(total_reg);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                op_reg    <= opcode;
                sx_reg    <= sample_x;
                sy_reg    <= sample_y;
                sel_reg   <= bin_select;
                tgt_reg   <= target;
                scale_reg <= x_scale;
                idx_reg   <= '0;
                prev_reg  <= '0;
                w_inr_reg <= 1'b0;
                w_fnd_reg <= 1'b0;
                w_bx_reg  <= '0;
                w_by_reg  <= '0;
                w_bc_reg  <= '0;
                w_qv_reg  <= '0;
            end
            S_CNT_MUL:
            begin
                mul_reg <= mul_p;
                ge_reg  <= sx_reg >= x_low_reg;
            end
            S_CNT_RD: bin_reg <= cnt_bin;
            S_CNT_WR: w_inr_reg <= 1'b1;
            S_RD_WAIT:
            begin
                if (sel_ok)
                begin
                    w_bx_reg <= mem_rdata.sum_x;
                    w_by_reg <= mem_rdata.sum_y;
                    w_bc_reg <= mem_rdata.cnt;
                end
            end
            S_Q_CHK:
            begin
                ent_reg <= mem_rdata;
                if (mem_rdata.cnt == 32'd0)
                    idx_reg <= idx_reg + (AW + 1)'(1);
            end
            S_Q_DIV1:
            begin
                if (div_done && !hit)
                begin
                    prev_reg <= div_q;
                    idx_reg  <= idx_reg + (AW + 1)'(1);
                end
            end
            S_Q_DIV2:
            begin
                if (div_done)
                begin
                    m2_reg <= div_q;
                    if (op_reg == OP_RISE)
                    begin
                        w_fnd_reg <= 1'b1;
                        w_qv_reg  <= div_q;
                    end
                end
            end
            S_Q_MUL: mul_reg <= mul_p;
            S_Q_SHF:
            begin
                w_fnd_reg <= 1'b1;
                w_qv_reg  <= shf_sat;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    o_inr_reg <= w_inr_reg;
                    o_bx_reg  <= w_bx_reg;
                    o_by_reg  <= w_by_reg;
                    o_bc_reg  <= w_bc_reg;
                    o_tot_reg <= total_reg;
                    o_out_reg <= outside_reg;
                    o_fnd_reg <= w_fnd_reg;
                    o_qv_reg  <= w_qv_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign in_range       = o_inr_reg;
    assign bin_sum_x      = o_bx_reg;
    assign bin_sum_y      = o_by_reg;
    assign bin_count      = o_bc_reg;
    assign total_counted  = o_tot_reg;
    assign rejected_count = o_out_reg;
    assign found          = o_fnd_reg;
    assign query_value    = o_qv_reg;

    a_div_in_query: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_Q_DIV1 || state_reg == S_Q_DIV2))
        else $error("divider finished outside a query");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR || state_reg == S_CNT_WR))
        else $error("bin memory written outside clear or count");

    a_count_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && opcode == OP_COUNT) |=> state_reg == S_CNT_MUL)
        else $error("count word did not start the multiply");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE)
        else $error("ready raised while busy");

endmodule

// File: hw/rtl/bha_mem.sv
// Bin storage: sums and count per bin, one write and one registered read port.
`timescale 1ns / 1ps
module bha_mem #(
    parameter int DEPTH = 1024
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [$clog2(DEPTH)-1:0]  waddr,
    input  bha_pkg::bha_entry_t       wdata,
    input  logic                      re,
    input  logic [$clog2(DEPTH)-1:0]  raddr,
    output bha_pkg::bha_entry_t       rdata
);
    import bha_pkg::*;

    bha_entry_t mem [DEPTH];
    bha_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/bha_div.sv
// Iterative signed 64 by unsigned 32 divider, truncating, saturated to 32 bits.
`timescale 1ns / 1ps
module bha_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] dividend,
    input  logic [31:0]        divisor,
    output logic               done,
    output logic signed [31:0] quotient
);
    import bha_pkg::*;

    logic        busy_reg;
    logic        fin_reg;
    logic [5:0]  step_reg;
    logic        neg_reg;
    logic [31:0] rem_reg;
    logic [63:0] q_reg;
    logic [31:0] dvs_reg;
    logic [33:0] trial;
    logic        fits;
    logic [31:0] nq;

    assign trial = {1'b0, rem_reg, q_reg[63]} - {2'b00, dvs_reg};
    assign fits  = ~trial[33];
    assign nq    = ~q_reg[31:0] + 32'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            fin_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 6'd1;
                if (step_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[63];
            q_reg   <= dividend[63] ? (64'd0 - dividend) : dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[31:0] : {rem_reg[30:0], q_reg[63]};
            q_reg   <= {q_reg[62:0], fits};
        end
    end

    always_comb
    begin
        if (!neg_reg)
            quotient = (q_reg > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q_reg[31:0];
        else
            quotient = (q_reg > 64'h8000_0000) ? 32'sh8000_0000 : nq;
    end

    assign done = fin_reg;

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the binned histogram accumulator.
`timescale 1ns / 1ps
module tb_top;
    import bha_pkg::*;

    localparam logic [2:0] OP_SPARE = 3'd5;
    localparam logic [2:0] OP_TOP   = 3'd7;
    localparam int NBINS = 1024;
    localparam int WATCHDOG_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_WORDS = 170;

    typedef struct {
        bit          inr;
        longint      sum_x;
        longint      sum_y;
        bit [31:0]   cnt;
        bit [31:0]   tot;
        bit [31:0]   rej;
        bit          fnd;
        bit [31:0]   qv;
    } hist_result_t;

    typedef struct {
        logic [2:0]  op;
        int          x;
        int          y;
        bit [9:0]    sel;
        int          tgt;
        int          scl;
        bit          typed;
        hist_result_t res;
    } stim_row_t;

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 0;
    logic in_ready;
    logic [2:0] opcode = '0;
    logic signed [31:0] sample_x = '0, sample_y = '0, target = '0, x_scale = '0;
    logic [9:0] bin_select = '0;
    logic out_valid;
    logic out_ready = 0;
    logic in_range, found;
    logic signed [63:0] bin_sum_x, bin_sum_y;
    logic [31:0] bin_count, total_counted, rejected_count;
    logic signed [31:0] query_value;

    binned_histogram_accumulator dut (.*);

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    // model state
    longint    hx [NBINS];
    longint    hy [NBINS];
    bit [31:0] hn [NBINS];
    bit [31:0] hist_total, hist_outside;
    int        cfg_xlow;
    bit [31:0] cfg_bpu;
    bit [10:0] cfg_bins;

    hist_result_t expected_q[$];
    int errors = 0;
    int idle_in = 0, stall_out = 0, hold_cnt = 0;

    function automatic bit [31:0] inc_sat(bit [31:0] c);
        return (c == 32'hFFFF_FFFF) ? c : c + 1;
    endfunction

    function automatic longint add_sat(longint a, longint b);
        longint s;
        s = a + b;
        if (b > 0 && s < a) return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (b < 0 && s > a) return 64'sh8000_0000_0000_0000;
        return s;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint bin_mean(longint s, bit [31:0] n);
        longint d;
        d = longint'(n);
        return clip32(s / d);
    endfunction

    function automatic int live_bins();
        return (cfg_bins < NBINS) ? int'(cfg_bins) : NBINS;
    endfunction

    function automatic hist_result_t histogram_step(logic [2:0] op, int x, int y,
                                                    bit [9:0] sel, int tgt, int scl);
        hist_result_t r;
        longint prev, m, prod;
        bit [63:0] diff, bin;
        int nb;
        r = '{default: 0};
        nb = live_bins();
        prev = 0;
        if (op == OP_COUNT) begin
            bin = 0;
            if (longint'(x) >= longint'(cfg_xlow)) begin
                diff = longint'(x) - longint'(cfg_xlow);
                bin = (diff * {32'd0, cfg_bpu}) >> 16;
                r.inr = (bin < nb);
            end
            if (r.inr) begin
                hx[bin] = add_sat(hx[bin], longint'(x));
                hy[bin] = add_sat(hy[bin], longint'(y));
                hn[bin] = inc_sat(hn[bin]);
                hist_total = inc_sat(hist_total);
            end
            else
                hist_outside = inc_sat(hist_outside);
        end
        else if (op == OP_CLEAR) begin
            for (int i = 0; i < NBINS; i++)
            begin
                hx[i] = 0; hy[i] = 0; hn[i] = 0;
            end
            hist_total = 0;
            hist_outside = 0;
        end
        else if (op == OP_READ) begin
            r.sum_x = hx[sel];
            r.sum_y = hy[sel];
            r.cnt = hn[sel];
        end
        else if (op == OP_RISE || op == OP_FALL) begin
            for (int i = 0; i < nb; i++)
            begin
                if (hn[i] == 0) continue;
                if (op == OP_RISE) begin
                    m = bin_mean(hx[i], hn[i]);
                    if (m > tgt && prev < tgt) begin
                        r.fnd = 1;
                        r.qv = 32'(bin_mean(hy[i], hn[i]));
                        break;
                    end
                end
                else begin
                    m = bin_mean(hy[i], hn[i]);
                    if (m < tgt && prev > tgt) begin
                        r.fnd = 1;
                        prod = longint'(scl) * bin_mean(hx[i], hn[i]);
                        r.qv = 32'(clip32(prod >>> 16));
                        break;
                    end
                end
                prev = m;
            end
        end
        r.tot = hist_total;
        r.rej = hist_outside;
        return r;
    endfunction

    task automatic reg_write(bha_reg_t idx, bit [31:0] val);
        @(negedge clk);
        psel = 1; pwrite = 1; penable = 0;
        paddr = 4'(idx) << 2;
        pwdata = val;
        @(negedge clk);
        penable = 1;
        @(negedge clk);
        psel = 0; penable = 0; pwrite = 0;
        case (idx)
            REG_X_LOW: cfg_xlow = val;
            REG_BPU:   cfg_bpu = val;
            default:   cfg_bins = val[10:0];
        endcase
    endtask

    task automatic send_word(stim_row_t s);
        hist_result_t r;
        while ($urandom_range(99) < idle_in)
            @(negedge clk);
        opcode = s.op; sample_x = s.x; sample_y = s.y;
        bin_select = s.sel; target = s.tgt; x_scale = s.scl;
        in_valid = 1;
        do
            @(posedge clk);
        while (!in_ready);
        r = histogram_step(s.op, s.x, s.y, s.sel, s.tgt, s.scl);
        expected_q.push_back(s.typed ? s.res : r);
        @(negedge clk);
        in_valid = 0;
    endtask

    task automatic drain();
        wait (expected_q.size() == 0);
        repeat (10) @(posedge clk);
    endtask

    function automatic int pick_x();
        longint span, off, v;
        int nb;
        nb = live_bins();
        if ($urandom_range(99) < 20) return $urandom;
        span = ((longint'(nb) + 1) << 16) / ((cfg_bpu == 0) ? 1 : longint'(cfg_bpu)) + 1;
        if (span > 64'd4294967295) span = 64'd4294967295;
        off = {$urandom, $urandom} % span;
        if (off < 0) off = -off;
        v = longint'(cfg_xlow) + off;
        return int'(clip32(v));
    endfunction

    function automatic stim_row_t random_word();
        stim_row_t s;
        int k;
        s = '{default: 0};
        k = $urandom_range(99);
        if (k < 60) s.op = OP_COUNT;
        else if (k < 78) s.op = OP_READ;
        else if (k < 86) s.op = OP_RISE;
        else if (k < 94) s.op = OP_FALL;
        else if (k < 96) s.op = OP_CLEAR;
        else s.op = 3'($urandom_range(OP_SPARE, OP_TOP));
        s.x = pick_x();
        s.y = ($urandom_range(1)) ? $urandom :
              $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        s.sel = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 40));
        s.tgt = ($urandom_range(1)) ? pick_x() : $urandom;
        s.scl = $urandom;
        return s;
    endfunction

    // directed rows; typed results hold for the reset configuration
    stim_row_t dir_rows[] = '{
        '{OP_READ,  0, 0, 10'd5, 0, 0, 1, '{0, 0, 0, 0, 0, 0, 0, 0}},
        '{OP_COUNT, 0, 0, 0, 0, 0, 1, '{1, 0, 0, 0, 1, 0, 0, 0}},
        '{OP_COUNT, -1, 5, 0, 0, 0, 1, '{0, 0, 0, 0, 1, 1, 0, 0}},
        '{OP_COUNT, 32'h7FFF_FFFF, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 1, 2, 0, 0}},
        '{OP_COUNT, 32'h8000_0000, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 1, 3, 0, 0}},
        '{OP_COUNT, 32'h0001_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, '{default: 0}},
        '{OP_COUNT, 32'h0001_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0, '{default: 0}},
        '{OP_COUNT, 32'h0002_0000, 32'h8000_0000, 0, 0, 0, 0, '{default: 0}},
        '{OP_COUNT, 32'h0003_0000, 32'h0010_0000, 0, 0, 0, 0, '{default: 0}},
        '{OP_COUNT, 32'h03FF_8000, -7, 0, 0, 0, 0, '{default: 0}},
        '{OP_READ,  0, 0, 10'd1, 0, 0, 0, '{default: 0}},
        '{OP_READ,  0, 0, 10'd1023, 0, 0, 0, '{default: 0}},
        '{OP_RISE,  0, 0, 0, 32'h0001_8000, 0, 0, '{default: 0}},
        '{OP_RISE,  0, 0, 0, 32'h7FFF_FFFF, 0, 0, '{default: 0}},
        '{OP_RISE,  0, 0, 0, 32'h8000_0000, 0, 0, '{default: 0}},
        '{OP_FALL,  0, 0, 0, 0, 32'h7FFF_FFFF, 0, '{default: 0}},
        '{OP_FALL,  0, 0, 0, 32'h0020_0000, 32'h8000_0000, 0, '{default: 0}},
        '{OP_FALL,  0, 0, 0, 32'h7FFF_FFFF, -32'sh0001_0000, 0, '{default: 0}},
        '{OP_SPARE, 0, 0, 0, 0, 0, 0, '{default: 0}},
        '{OP_TOP,   0, 0, 0, 0, 0, 0, '{default: 0}},
        '{OP_CLEAR, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 0, 0, 0}},
        '{OP_RISE,  0, 0, 0, 32'h8000_0000, 0, 1, '{0, 0, 0, 0, 0, 0, 0, 0}},
        '{OP_READ,  0, 0, 10'd1023, 0, 0, 1, '{0, 0, 0, 0, 0, 0, 0, 0}}
    };

    // result side: random stalls plus an optional long hold-off
    always @(negedge clk)
    begin
        if (hold_cnt > 0) begin
            out_ready = 0;
            hold_cnt = hold_cnt - 1;
        end
        else
            out_ready = ($urandom_range(99) >= stall_out);
    end

    always @(posedge clk)
    begin
        hist_result_t e;
        if (rst_n && out_valid && out_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result word", $time);
                errors++;
            end
            else begin
                e = expected_q.pop_front();
                if (in_range !== e.inr || bin_sum_x !== e.sum_x || bin_sum_y !== e.sum_y
                    || bin_count !== e.cnt || total_counted !== e.tot
                    || rejected_count !== e.rej || found !== e.fnd || query_value !== e.qv)
                begin
                    $display({"%0t: mismatch exp inr=%0d sx=%0d sy=%0d cnt=%0d tot=%0d",
                              " rej=%0d fnd=%0d qv=%0d"},
                             $time, e.inr, e.sum_x, e.sum_y, e.cnt, e.tot, e.rej, e.fnd,
                             $signed(e.qv));
                    $display({"%0t:          act inr=%0d sx=%0d sy=%0d cnt=%0d tot=%0d",
                              " rej=%0d fnd=%0d qv=%0d"},
                             $time, in_range, bin_sum_x, bin_sum_y, bin_count, total_counted,
                             rejected_count, found, query_value);
                    errors++;
                end
            end
        end
    end

    int quiet = 0;
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet == WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        stim_row_t s;
        for (int i = 0; i < NBINS; i++)
        begin
            hx[i] = 0; hy[i] = 0; hn[i] = 0;
        end
        hist_total = 0; hist_outside = 0;
        cfg_xlow = 0; cfg_bpu = 32'd65536; cfg_bins = 11'd1024;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        foreach (dir_rows[i])
            send_word(dir_rows[i]);

        for (int p = 0; p < 6; p++)
        begin
            drain();
            case (p)
                0: begin reg_write(REG_X_LOW, 0); reg_write(REG_BPU, 32'd65536);
                         reg_write(REG_BINS, 16); end
                1: begin reg_write(REG_X_LOW, 32'h8000_0000); reg_write(REG_BPU, 32'hFFFF_FFFF);
                         reg_write(REG_BINS, 1); end
                2: begin reg_write(REG_X_LOW, $urandom); reg_write(REG_BPU,
                         $urandom_range(32'h0000_1000, 32'h0010_0000)); reg_write(REG_BINS, 8); end
                3: begin reg_write(REG_X_LOW, 32'h7FFF_FFFF); reg_write(REG_BPU, 0);
                         reg_write(REG_BINS, 0); end
                4: begin reg_write(REG_X_LOW, -32'sh0004_0000); reg_write(REG_BPU, 32'h0004_0000);
                         reg_write(REG_BINS, 11'd2047); end
                default: begin reg_write(REG_X_LOW, $urandom); reg_write(REG_BPU, $urandom);
                         reg_write(REG_BINS, $urandom_range(1, 32)); end
            endcase
            case (p % 4)
                0: begin idle_in = 0; stall_out = 0; end
                1: begin idle_in = 70; stall_out = 0; end
                2: begin idle_in = 0; stall_out = 70; end
                default: begin idle_in = 21; stall_out = 21; end
            endcase
            if (p == 2)
                hold_cnt = HOLD_CYCLES;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                s = random_word();
                send_word(s);
            end
        end

        wait (expected_q.size() == 0);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/bha_pkg.sv
hw/rtl/bha_mem.sv
hw/rtl/bha_div.sv
hw/rtl/binned_histogram_accumulator.sv
test/tb_top.sv
